// ===== design/psgb_pkg.sv =====
`default_nettype none
package psgb_pkg;

	// field widths
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int POS_W  = 8;
	localparam int OP_W   = 2;
	localparam int CFG_W  = 9;
	localparam int IDX_W  = 1;
	// 3x3 sum of one channel: 255 * 16 fits in 12 bits
	localparam int ACC_W  = CH_W + 4;
	localparam int DIV_SH = 4;

	// default store geometry
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// size register reset value
	localparam logic [CFG_W-1:0] SIZE_RST = 9'd256;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 1'b1;

	// opcodes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_BLUR  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_RDWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_WRBACK,
		ST_DONE
	} st_t;

endpackage
`default_nettype wire

// ===== design/pixel_store_point_gaussian_blur.sv =====
`default_nettype none
// channel    | handshake                      | payload
// -----------+--------------------------------+-------------------------------------------
// input      | in_valid / in_stall            | opcode, row, col, in_blue/green/red
// output     | out_valid / out_stall          | out_blue/green/red, bad_position
// config     | wr_en (no wait)                | wr_index, wr_data
//
// one request at a time through a single-port pixel store and per-channel accumulators.
// write: ST_WRITE; read: ST_READ, ST_RDWAIT; blur: ST_SCAN over nine neighbors, reading
// the in-image ones, then ST_DRAIN, ST_WRBACK; bad positions and opcode 3 go to ST_DONE.
// a finished result sits in the output register; the next request is taken while
// it waits, and a request only stalls at its end if the previous result is unread.
// reset clears control and size registers; the store is not cleared.
module pixel_store_point_gaussian_blur #(
	parameter int MAX_WIDTH  = psgb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = psgb_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [psgb_pkg::OP_W-1:0]  opcode,
	input  wire logic [psgb_pkg::POS_W-1:0] row,
	input  wire logic [psgb_pkg::POS_W-1:0] col,
	input  wire logic [psgb_pkg::CH_W-1:0]  in_blue,
	input  wire logic [psgb_pkg::CH_W-1:0]  in_green,
	input  wire logic [psgb_pkg::CH_W-1:0]  in_red,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [psgb_pkg::CH_W-1:0]  out_blue,
	output logic      [psgb_pkg::CH_W-1:0]  out_green,
	output logic      [psgb_pkg::CH_W-1:0]  out_red,
	output logic                            bad_position,
	// configuration
	input  wire logic                       wr_en,
	input  wire logic [psgb_pkg::IDX_W-1:0] wr_index,
	input  wire logic [psgb_pkg::CFG_W-1:0] wr_data
);
	import psgb_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	// size registers hold at most 511, so a larger limit never clamps
	localparam int W_CAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
	localparam int H_CAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

	st_t st_q, st_d;

	logic [CFG_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] w_eff, h_eff;
	logic             in_req, out_req, bad_in;

	logic [POS_W-1:0] row_q, col_q;
	logic [PIX_W-1:0] pix_q;
	logic             bad_q;
	logic [1:0]       dr_q, dc_q;
	logic [ACC_W-1:0] acc_q [3];
	logic             rd_s1;
	logic [1:0]       sh_s1;

	logic [CFG_W-1:0] nr, nc;
	logic             nb_in;
	logic [1:0]       nb_sh;
	logic [POS_W-1:0] ar, ac;
	logic             mem_en, mem_we;
	logic [AW-1:0]    mem_addr;
	logic [PIX_W-1:0] mem_wdata, mem_rdata;
	logic [PIX_W-1:0] blur_pix;
	logic             out_load;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RST;
			height_q <= SIZE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// effective image size and position check
	always_comb begin
		w_eff  = (width_q > CFG_W'(W_CAP)) ? CFG_W'(W_CAP) : width_q;
		h_eff  = (height_q > CFG_W'(H_CAP)) ? CFG_W'(H_CAP) : height_q;
		bad_in = ({1'b0, row} >= h_eff) || ({1'b0, col} >= w_eff);
	end

	assign in_stall = (st_q != ST_IDLE);
	assign in_req   = in_valid && !in_stall;
	assign out_req  = out_valid && !out_stall;

	// neighbor under the scan counters
	always_comb begin
		nr    = {1'b0, row_q} + {7'b0, dr_q} - 9'd1;
		nc    = {1'b0, col_q} + {7'b0, dc_q} - 9'd1;
		nb_in = !(dr_q == 2'd0 && row_q == '0) && !(dc_q == 2'd0 && col_q == '0)
			&& (nr < h_eff) && (nc < w_eff);
		// weight 1, 2 or 4 as a left shift
		nb_sh = {1'b0, dr_q == 2'd1} + {1'b0, dc_q == 2'd1};
	end

	// blurred pixel from the accumulators
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			blur_pix[i*CH_W +: CH_W] = acc_q[i][DIV_SH +: CH_W];
		end
	end

	// store port
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		ar        = row_q;
		ac        = col_q;
		mem_wdata = pix_q;
		unique case (st_q)
			ST_WRITE: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
			ST_READ: begin
				mem_en = 1'b1;
			end
			ST_SCAN: begin
				mem_en = nb_in;
				ar     = nr[POS_W-1:0];
				ac     = nc[POS_W-1:0];
			end
			ST_WRBACK: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_wdata = blur_pix;
			end
			default: ;
		endcase
		mem_addr = AW'(32'(ar) * MAX_WIDTH + 32'(ac));
	end

	psgb_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state
	always_comb begin
		st_d     = st_q;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_req) begin
					if (bad_in) begin
						st_d = ST_DONE;
					end else begin
						case (opcode)
							OP_WRITE: st_d = ST_WRITE;
							OP_READ:  st_d = ST_READ;
							OP_BLUR:  st_d = ST_SCAN;
							default:  st_d = ST_DONE;
						endcase
					end
				end
			end
			ST_WRITE:  st_d = ST_DONE;
			ST_READ:   st_d = ST_RDWAIT;
			ST_RDWAIT: st_d = ST_DONE;
			ST_SCAN: begin
				if (dr_q == 2'd2 && dc_q == 2'd2) begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  st_d = ST_WRBACK;
			ST_WRBACK: st_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default:   st_d = ST_IDLE;
		endcase
	end

	// request capture, scan counters and pixel result
	always_ff @(posedge clk) begin
		if (in_req) begin
			row_q <= row;
			col_q <= col;
			bad_q <= bad_in;
			dr_q  <= 2'd0;
			dc_q  <= 2'd0;
			// write data, or zero for a result with nothing to return
			if (!bad_in && opcode == OP_WRITE) begin
				pix_q <= {in_red, in_green, in_blue};
			end else begin
				pix_q <= '0;
			end
		end else begin
			if (st_q == ST_SCAN) begin
				if (dc_q == 2'd2) begin
					dc_q <= 2'd0;
					dr_q <= dr_q + 2'd1;
				end else begin
					dc_q <= dc_q + 2'd1;
				end
			end
			if (st_q == ST_RDWAIT) begin
				pix_q <= mem_rdata;
			end
			if (st_q == ST_WRBACK) begin
				pix_q <= blur_pix;
			end
		end
	end

	// read tag for the accumulator, registered to line up with the store's registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			sh_s1 <= 2'd0;
		end else begin
			rd_s1 <= (st_q == ST_SCAN) && nb_in;
			sh_s1 <= nb_sh;
		end
	end

	// shared weighted accumulator, one neighbor a cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (in_req) begin
				acc_q[i] <= '0;
			end else if (rd_s1) begin
				acc_q[i] <= acc_q[i]
					+ (ACC_W'(mem_rdata[i*CH_W +: CH_W]) << sh_s1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_req) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_blue     <= pix_q[0 +: CH_W];
			out_green    <= pix_q[CH_W +: CH_W];
			out_red      <= pix_q[2*CH_W +: CH_W];
			bad_position <= bad_q;
		end
	end

endmodule
`default_nettype wire

// ===== design/psgb_store.sv =====
`default_nettype none
module psgb_store #(
	parameter int DEPTH = psgb_pkg::DEF_MAX_WIDTH * psgb_pkg::DEF_MAX_HEIGHT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              addr,
	input  wire logic [psgb_pkg::PIX_W-1:0] wdata,
	output logic      [psgb_pkg::PIX_W-1:0] rdata
);
	import psgb_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== verif/tb_pixel_store_point_gaussian_blur.sv =====
module tb_pixel_store_point_gaussian_blur;
	timeunit 1ns;
	timeprecision 1ps;

	import psgb_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int MAX_MISMATCH_LINES = 20;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            bad;
	} pixel_result_t;

	// predicted pixel store, size registers and the queue of expected results
	class blur_scoreboard;
		logic [PIX_W-1:0] pixels [STORE_DEPTH];
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		pixel_result_t    expected_q [$];
		int               errors;
		int               results_seen;
		int               op_count [4];
		int               bad_count;

		function new();
			width_reg = SIZE_RST;
			height_reg = SIZE_RST;
			errors = 0;
			results_seen = 0;
			bad_count = 0;
			foreach (op_count[i])
				op_count[i] = 0;
		endfunction

		static function int clamp_dim(logic [CFG_W-1:0] v, int lim);
			return (v > lim) ? lim : int'(v);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_size(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == REG_WIDTH)
				width_reg = v;
			else
				height_reg = v;
		endfunction

		// weighted 3x3 sum per channel, neighbors outside the image left out, divided by 16
		function logic [PIX_W-1:0] blur_value(int r, int c, int ew, int eh);
			int sum [3];
			int nr;
			int nc;
			int wgt;
			logic [PIX_W-1:0] px;
			logic [PIX_W-1:0] res;
			sum = '{0, 0, 0};
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					nr = r + dr;
					nc = c + dc;
					if (nr < 0 || nc < 0 || nr >= eh || nc >= ew)
						continue;
					wgt = ((dr == 0) ? 2 : 1) * ((dc == 0) ? 2 : 1);
					px = pixels[nr * DEF_MAX_WIDTH + nc];
					for (int ch = 0; ch < 3; ch++)
						sum[ch] += int'(px[CH_W*ch +: CH_W]) * wgt;
				end
			end
			for (int ch = 0; ch < 3; ch++)
				res[CH_W*ch +: CH_W] = CH_W'(sum[ch] >> DIV_SH);
			return res;
		endfunction

		// accepted request: update the store copy and queue the expected result
		function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] r,
			logic [POS_W-1:0] c, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
			logic [CH_W-1:0] rd);
			int ew;
			int eh;
			int idx;
			logic [PIX_W-1:0] px;
			pixel_result_t exp_res;
			ew = clamp_dim(width_reg, DEF_MAX_WIDTH);
			eh = clamp_dim(height_reg, DEF_MAX_HEIGHT);
			idx = int'(r) * DEF_MAX_WIDTH + int'(c);
			px = '0;
			exp_res.bad = (int'(r) >= eh) || (int'(c) >= ew);
			op_count[op]++;
			if (exp_res.bad) begin
				bad_count++;
			end else begin
				case (op)
					OP_WRITE: begin
						px = {rd, g, b};
						pixels[idx] = px;
					end
					OP_BLUR: begin
						px = blur_value(r, c, ew, eh);
						pixels[idx] = px;
					end
					OP_READ: begin
						px = pixels[idx];
					end
					default: begin
						px = '0;
					end
				endcase
			end
			exp_res.blue = px[CH_W-1:0];
			exp_res.green = px[2*CH_W-1:CH_W];
			exp_res.red = px[3*CH_W-1:2*CH_W];
			expected_q.push_back(exp_res);
		endfunction

		task report_mismatch(string what, logic [CH_W-1:0] expv, logic [CH_W-1:0] gotv);
			errors++;
			if (errors <= MAX_MISMATCH_LINES)
				$display("%0t mismatch on %s: expected %h, got %h", $time, what, expv, gotv);
		endtask

		// accepted result against the oldest expectation
		task check_result(pixel_result_t got);
			pixel_result_t exp_res;
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", '0, got.blue);
				return;
			end
			exp_res = expected_q.pop_front();
			results_seen++;
			if (got.blue !== exp_res.blue)
				report_mismatch("out_blue", exp_res.blue, got.blue);
			if (got.green !== exp_res.green)
				report_mismatch("out_green", exp_res.green, got.green);
			if (got.red !== exp_res.red)
				report_mismatch("out_red", exp_res.red, got.red);
			if (got.bad !== exp_res.bad)
				report_mismatch("bad_position", CH_W'(exp_res.bad), CH_W'(got.bad));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     opcode = OP_WRITE;
	logic [POS_W-1:0]    row = '0;
	logic [POS_W-1:0]    col = '0;
	logic [CH_W-1:0]     in_blue = '0;
	logic [CH_W-1:0]     in_green = '0;
	logic [CH_W-1:0]     in_red = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [CH_W-1:0]     out_blue;
	logic [CH_W-1:0]     out_green;
	logic [CH_W-1:0]     out_red;
	logic                bad_position;
	logic                wr_en = 1'b0;
	logic [IDX_W-1:0]    wr_index = REG_WIDTH;
	logic [CFG_W-1:0]    wr_data = '0;

	blur_scoreboard scoreboard = new();

	// stimulus side bookkeeping: which entries hold a written pixel
	bit               written [STORE_DEPTH];
	logic [CFG_W-1:0] size_w = SIZE_RST;
	logic [CFG_W-1:0] size_h = SIZE_RST;
	int               send_gap_pct = 0;
	int               recv_stall_pct = 0;
	int               sizes_run = 1;

	pixel_store_point_gaussian_blur DUT (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random stall, check every accepted result
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall)
			scoreboard.check_result({out_red, out_green, out_blue, bad_position});
	end

	// run limit
	initial begin
		#5ms;
		$display("timeout waiting for the block");
		$display("*** FAILED ***");
		$finish;
	end

	function automatic bit outside_image(int r, int c);
		return r >= blur_scoreboard::clamp_dim(size_h, DEF_MAX_HEIGHT) ||
			c >= blur_scoreboard::clamp_dim(size_w, DEF_MAX_WIDTH);
	endfunction

	// a read or blur may only touch entries that were written
	function automatic bit store_ready(logic [OP_W-1:0] op, int r, int c);
		if (outside_image(r, c))
			return 1'b1;
		if (op == OP_READ)
			return written[r * DEF_MAX_WIDTH + c];
		if (op == OP_BLUR) begin
			for (int nr = r - 1; nr <= r + 1; nr++)
				for (int nc = c - 1; nc <= c + 1; nc++)
					if (nr >= 0 && nc >= 0 && !outside_image(nr, nc) &&
						!written[nr * DEF_MAX_WIDTH + nc])
						return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [CH_W-1:0] random_channel();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return CH_W'($urandom_range(255));
	endfunction

	// window origin: at either end of the image or anywhere in between
	function automatic int pick_origin(int extent, int span);
		case ($urandom_range(2))
			0: return 0;
			1: return extent - span;
			default: return $urandom_range(extent - span, 0);
		endcase
	endfunction

	// one request, held until accepted; the sender idles cycle by cycle first
	task automatic send_request(input logic [OP_W-1:0] op, input int r, input int c,
		input logic [CH_W-1:0] b, input logic [CH_W-1:0] g, input logic [CH_W-1:0] rd);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		if (op == OP_WRITE && !outside_image(r, c))
			written[r * DEF_MAX_WIDTH + c] = 1'b1;
		in_valid <= 1'b1;
		opcode <= op;
		row <= POS_W'(r);
		col <= POS_W'(c);
		in_blue <= b;
		in_green <= g;
		in_red <= rd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		scoreboard.note_request(op, POS_W'(r), POS_W'(c), b, g, rd);
	endtask

	// size registers are written only once every result is back
	task automatic set_image_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		in_valid <= 1'b0;
		while (scoreboard.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_WIDTH;
		wr_data <= w;
		@(posedge clk);
		wr_index <= REG_HEIGHT;
		wr_data <= h;
		@(posedge clk);
		wr_en <= 1'b0;
		scoreboard.set_size(REG_WIDTH, w);
		scoreboard.set_size(REG_HEIGHT, h);
		size_w = w;
		size_h = h;
		sizes_run++;
	endtask

	// fill a small window of the image, then a random mix mostly inside it
	task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input int n_mix);
		int ew;
		int eh;
		int ww;
		int wh;
		int r0;
		int c0;
		int r;
		int c;
		int pick;
		logic [OP_W-1:0] op;
		set_image_size(w, h);
		ew = blur_scoreboard::clamp_dim(w, DEF_MAX_WIDTH);
		eh = blur_scoreboard::clamp_dim(h, DEF_MAX_HEIGHT);
		ww = (ew < 4) ? ew : 4;
		wh = (eh < 4) ? eh : 4;
		r0 = pick_origin(eh, wh);
		c0 = pick_origin(ew, ww);
		for (int rr = 0; rr < wh; rr++)
			for (int cc = 0; cc < ww; cc++)
				send_request(OP_WRITE, r0 + rr, c0 + cc, random_channel(),
					random_channel(), random_channel());
		repeat (n_mix) begin
			pick = $urandom_range(99);
			if (pick < 30)
				op = OP_WRITE;
			else if (pick < 65)
				op = OP_BLUR;
			else if (pick < 90)
				op = OP_READ;
			else if (pick < 95)
				op = OP_UNUSED;
			else
				op = OP_WRITE;
			if (ww > 0 && wh > 0 && $urandom_range(99) < 85) begin
				r = r0 + $urandom_range(wh - 1);
				c = c0 + $urandom_range(ww - 1);
			end else begin
				r = $urandom_range(255);
				c = $urandom_range(255);
			end
			if (!store_ready(op, r, c))
				op = OP_WRITE;
			send_request(op, r, c, random_channel(), random_channel(), random_channel());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 32;
		recv_stall_pct = 45;

		// full 256x256 image after reset: three corners and the right edge
		send_request(OP_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_request(OP_WRITE, 0, 1, 8'h00, 8'h00, 8'h00);
		send_request(OP_WRITE, 1, 0, 8'h80, 8'h7F, 8'h01);
		send_request(OP_WRITE, 1, 1, 8'hFF, 8'h00, 8'hFF);
		send_request(OP_BLUR, 0, 0, 8'h00, 8'h00, 8'h00);
		send_request(OP_READ, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_request(OP_WRITE, 0, 254, 8'h12, 8'hFF, 8'h34);
		send_request(OP_WRITE, 0, 255, 8'hFF, 8'h56, 8'h00);
		send_request(OP_WRITE, 1, 254, 8'h00, 8'hAB, 8'hFF);
		send_request(OP_WRITE, 1, 255, 8'hFF, 8'hFF, 8'h01);
		// top-right corner
		send_request(OP_BLUR, 0, 255, 8'h00, 8'h00, 8'h00);
		send_request(OP_WRITE, 2, 254, 8'h55, 8'hAA, 8'hFF);
		send_request(OP_WRITE, 2, 255, 8'hAA, 8'h55, 8'h00);
		// right edge
		send_request(OP_BLUR, 1, 255, 8'hFF, 8'hFF, 8'hFF);
		send_request(OP_READ, 1, 255, 8'h00, 8'h00, 8'h00);
		send_request(OP_WRITE, 255, 255, 8'hFF, 8'hFF, 8'hFF);
		send_request(OP_WRITE, 254, 255, 8'hFF, 8'hFF, 8'hFF);
		send_request(OP_WRITE, 255, 254, 8'hFF, 8'hFF, 8'hFF);
		send_request(OP_WRITE, 254, 254, 8'hFF, 8'hFF, 8'hFF);
		// bottom-right corner
		send_request(OP_BLUR, 255, 255, 8'h00, 8'h00, 8'h00);
		send_request(OP_READ, 255, 255, 8'h00, 8'h00, 8'h00);
		// unused opcode inside the image
		send_request(OP_UNUSED, 3, 3, 8'hFF, 8'hFF, 8'hFF);

		// zero sizes and size one first, then the minimum and clamped sizes
		run_phase(9'd0, 9'd7, 30);
		run_phase(9'd5, 9'd0, 30);
		run_phase(9'd1, 9'd5, 30);
		run_phase(9'd6, 9'd1, 30);

		send_gap_pct = 45;
		recv_stall_pct = 32;
		run_phase(9'd2, 9'd2, 30);
		run_phase(9'd511, 9'd511, 30);
		run_phase(9'd300, 9'd256, 30);
		run_phase(9'd3, 9'd4, 30);
		run_phase(9'd256, 9'd2, 30);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_phase(9'd2, 9'd256, 30);
		run_phase(9'd9, 9'd6, 30);
		run_phase(9'd1, 9'd1, 30);
		run_phase(9'd17, 9'd11, 30);

		// drain and watch for stray results
		in_valid <= 1'b0;
		while (scoreboard.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("requests: %0d writes, %0d blurs, %0d reads, %0d unused opcode, %0d off-image",
			scoreboard.op_count[OP_WRITE], scoreboard.op_count[OP_BLUR],
			scoreboard.op_count[OP_READ], scoreboard.op_count[OP_UNUSED],
			scoreboard.bad_count);
		$display("%0d results checked across %0d image sizes, %0d mismatches",
			scoreboard.results_seen, sizes_run, scoreboard.errors);
		if (scoreboard.errors == 0 && scoreboard.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
design/psgb_pkg.sv
design/psgb_store.sv
design/pixel_store_point_gaussian_blur.sv
verif/tb_pixel_store_point_gaussian_blur.sv
